[design/sellp_pkg.sv]
// Package: shared types, widths and constants of the SELL-P slice table builder.
`timescale 1ns / 1ps

package sellp_pkg;

  localparam int ROW_PTR_W     = 31;
  localparam int SLICE_NUM_W   = 31;
  localparam int SLICE_WIDTH_W = 32;
  localparam int OFFSET_W      = 40;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int DIV_W         = 32;

  localparam int INDEX_BITS_DEF  = 31;
  localparam int OFFSET_BITS_DEF = 40;

  localparam logic [CFG_W-1:0] ROWS_PER_SLICE_RST = 9'd64;
  localparam logic [CFG_W-1:0] WIDTH_MULTIPLE_RST = 9'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_PER_SLICE = 1'b0,
    REG_WIDTH_MULTIPLE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_PTR_W-1:0] row_pointer;
    logic                 final_entry;
  } in_item_t;

  typedef struct packed {
    logic [SLICE_NUM_W-1:0]   slice_number;
    logic [SLICE_WIDTH_W-1:0] slice_width;
    logic [OFFSET_W-1:0]      slice_start;
    logic [OFFSET_W-1:0]      slice_finish;
    logic                     last_slice;
    logic                     overflow;
  } out_item_t;

endpackage

[design/sellp_rem_unit.sv]
// Radix-2 restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps

module sellp_rem_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sellp_pkg::DIV_W-1:0] dividend,
  input  logic [sellp_pkg::CFG_W-1:0] divisor,
  output logic                       done,
  output logic [sellp_pkg::CFG_W-1:0] remainder
);
  import sellp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

  logic                busy_r,    busy_nxt;
  logic                done_r,    done_nxt;
  logic [CNT_W-1:0]    cnt_r,     cnt_nxt;
  logic [DIV_W-1:0]    dvd_r,     dvd_nxt;
  logic [CFG_W-1:0]    dsr_r,     dsr_nxt;
  logic [CFG_W-1:0]    rem_r,     rem_nxt;
  logic [CFG_W:0]      shifted;
  logic [CFG_W:0]      diff;
  logic                fits;

  always_comb begin
    shifted  = {rem_r, dvd_r[DIV_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    fits     = shifted >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[design/sellp_slice_set_builder.sv]
// Top level: builds SELL-P slice widths and offsets from a CSR row-pointer stream.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  in_item_t  (row_pointer, final_entry)
//   out_     output     out_valid/out_ready out_item_t (slice number, width, offsets, flags)
//   cfg_     input      cfg_wr_en          cfg_index, cfg_wdata
//
// The first entry of a matrix only records its row pointer; every later entry passes the
// divide and row steps, and the emit step too when it closes a slice. The divide step waits
// for the 32 steps of the remainder unit that rounds the row length up.
// A slice result waits in the output register; the block still takes the next entry,
// and stalls in its emit step only if a second result is due before the first transfer.
// Reset is synchronous and active low and restores every register but x_r and out_data_r.
`timescale 1ns / 1ps

module sellp_slice_set_builder #(
  parameter int INDEX_BITS  = sellp_pkg::INDEX_BITS_DEF,
  parameter int OFFSET_BITS = sellp_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sellp_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sellp_pkg::out_item_t          out_data,
  input  logic                          cfg_wr_en,
  input  logic [sellp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sellp_pkg::CFG_W-1:0]   cfg_wdata
);
  import sellp_pkg::*;

  localparam int PTR_BITS = (INDEX_BITS < ROW_PTR_W) ? INDEX_BITS : ROW_PTR_W;
  localparam logic [ROW_PTR_W-1:0] PTR_MASK = (ROW_PTR_W'(1) << PTR_BITS) - 1'b1;
  localparam int SUM_W = ((OFFSET_BITS > SLICE_WIDTH_W) ? OFFSET_BITS : SLICE_WIDTH_W) + 1;
  localparam logic [SUM_W-1:0] OFF_MAX = SUM_W'({OFFSET_BITS{1'b1}});

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ROW,
    S_EMIT
  } state_t;

  state_t                   state_r,    state_nxt;
  logic [CFG_W-1:0]         rps_r,      rps_nxt;
  logic [CFG_W-1:0]         wm_r,       wm_nxt;
  logic [ROW_PTR_W-1:0]     prev_r,     prev_nxt;
  logic                     have_prev_r, have_prev_nxt;
  logic [CFG_W-1:0]         rows_r,     rows_nxt;
  logic [SLICE_WIDTH_W-1:0] max_r,      max_nxt;
  logic [OFFSET_BITS-1:0]   offset_r,   offset_nxt;
  logic [INDEX_BITS-1:0]    cnt_r,      cnt_nxt;
  logic                     sat_r,      sat_nxt;
  logic                     fin_r,      fin_nxt;
  logic [DIV_W-1:0]         x_r,        x_nxt;
  logic [CFG_W-1:0]         mult_r,     mult_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     in_fire;
  logic                     div_start;
  logic                     rem_done;
  logic [CFG_W-1:0]         rem;
  logic [ROW_PTR_W-1:0]     cur;
  logic [ROW_PTR_W-1:0]     len;
  logic [CFG_W-1:0]         mult;
  logic [CFG_W-1:0]         limit;
  logic [SLICE_WIDTH_W-1:0] rounded;
  logic [SUM_W-1:0]         sum;
  logic                     sum_sat;
  logic [OFFSET_BITS-1:0]   finish;
  logic                     out_free;

  sellp_rem_unit u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (x_nxt),
    .divisor   (mult_nxt),
    .done      (rem_done),
    .remainder (rem)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cur     = in_data.row_pointer & PTR_MASK;
    len     = (cur >= prev_r) ? (cur - prev_r) : '0;
    mult    = (wm_r != '0) ? wm_r : CFG_W'(1);
    limit   = (rps_r != '0) ? rps_r : CFG_W'(1);
    rounded = x_r - DIV_W'(rem);
    sum     = SUM_W'(offset_r) + SUM_W'(max_r);
    sum_sat = sum > OFF_MAX;
    finish  = sum_sat ? OFF_MAX[OFFSET_BITS-1:0] : sum[OFFSET_BITS-1:0];

    state_nxt     = state_r;
    rps_nxt       = rps_r;
    wm_nxt        = wm_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    rows_nxt      = rows_r;
    max_nxt       = max_r;
    offset_nxt    = offset_r;
    cnt_nxt       = cnt_r;
    sat_nxt       = sat_r;
    fin_nxt       = fin_r;
    x_nxt         = x_r;
    mult_nxt      = mult_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS_PER_SLICE: rps_nxt = cfg_wdata;
        REG_WIDTH_MULTIPLE: wm_nxt  = cfg_wdata;
        default:            rps_nxt = rps_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!have_prev_r) begin
            if (in_data.final_entry) begin
              prev_nxt      = '0;
              have_prev_nxt = 1'b0;
              rows_nxt      = '0;
              max_nxt       = '0;
              offset_nxt    = '0;
              cnt_nxt       = '0;
              sat_nxt       = 1'b0;
            end else begin
              prev_nxt      = cur;
              have_prev_nxt = 1'b1;
            end
          end else begin
            prev_nxt  = cur;
            fin_nxt   = in_data.final_entry;
            mult_nxt  = mult;
            x_nxt     = DIV_W'(len) + DIV_W'(mult) - DIV_W'(1);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rem_done) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        if (rounded > max_r) begin
          max_nxt = rounded;
        end
        rows_nxt = rows_r + 1'b1;
        if ((rows_nxt < limit) && !fin_r) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.slice_number = SLICE_NUM_W'(cnt_r);
          out_data_nxt.slice_width  = max_r;
          out_data_nxt.slice_start  = OFFSET_W'(offset_r);
          out_data_nxt.slice_finish = OFFSET_W'(finish);
          out_data_nxt.last_slice   = fin_r;
          out_data_nxt.overflow     = sat_r || sum_sat;
          if (fin_r) begin
            prev_nxt      = '0;
            have_prev_nxt = 1'b0;
            offset_nxt    = '0;
            cnt_nxt       = '0;
            sat_nxt       = 1'b0;
          end else begin
            offset_nxt = finish;
            cnt_nxt    = cnt_r + 1'b1;
            sat_nxt    = sat_r || sum_sat;
          end
          rows_nxt  = '0;
          max_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    div_start = (state_r == S_IDLE) && (state_nxt == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rps_r       <= ROWS_PER_SLICE_RST;
      wm_r        <= WIDTH_MULTIPLE_RST;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      rows_r      <= '0;
      max_r       <= '0;
      offset_r    <= '0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      fin_r       <= 1'b0;
      mult_r      <= CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rps_r       <= rps_nxt;
      wm_r        <= wm_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      rows_r      <= rows_nxt;
      max_r       <= max_nxt;
      offset_r    <= offset_nxt;
      cnt_r       <= cnt_nxt;
      sat_r       <= sat_nxt;
      fin_r       <= fin_nxt;
      mult_r      <= mult_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    out_data_r <= out_data_nxt;
  end

  // A result only appears after the emit step.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared outside the emit step");

  // The remainder unit only finishes while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> state_r == S_DIV)
    else $error("remainder finished outside the divide step");

  // The remainder stays below the divisor used for the row.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> rem < mult_r)
    else $error("remainder not below the width multiple");

endmodule
